/* rtl/core/dps_pkg.sv */
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and constants for the dynamic priority scheduler.
// ----------------------------------------------------------------------------
package dps_pkg;

  localparam int DPS_MAX_PROCS = 8;
  localparam int DPS_TIME_BITS = 8;

  localparam int ID_W  = 4;
  localparam int PRI_W = 8;
  localparam int OUT_TIME_W = 8;
  localparam int NEED_W = 8;
  localparam int CLK_W = 16;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic signed [PRI_W-1:0] PRI_MIN = {1'b1, {(PRI_W-1){1'b0}}};

  typedef enum logic [2:0] {
    STAT_RAN      = 3'd0,
    STAT_FINISHED = 3'd1,
    STAT_IDLE     = 3'd2,
    STAT_LOADED   = 3'd3,
    STAT_REJECTED = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_REINS
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_POP
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     strict;
  } cell_ctrl_t;

endpackage

/* rtl/core/dps_cell.sv */
// ----------------------------------------------------------------------------
// dps_cell
// One slot of the sorted process chain: holds an entry, inserts or shifts.
// ----------------------------------------------------------------------------
module dps_cell #(
  parameter int TIME_BITS = dps_pkg::DPS_TIME_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  dps_pkg::cell_ctrl_t                 ctrl,
  input  logic [dps_pkg::ID_W-1:0]            new_id,
  input  logic [TIME_BITS-1:0]                new_used,
  input  logic [TIME_BITS-1:0]                new_left,
  input  logic signed [dps_pkg::PRI_W-1:0]    new_pri,
  input  logic                                prev_valid,
  input  logic [dps_pkg::ID_W-1:0]            prev_id,
  input  logic [TIME_BITS-1:0]                prev_used,
  input  logic [TIME_BITS-1:0]                prev_left,
  input  logic signed [dps_pkg::PRI_W-1:0]    prev_pri,
  input  logic                                next_valid,
  input  logic [dps_pkg::ID_W-1:0]            next_id,
  input  logic [TIME_BITS-1:0]                next_used,
  input  logic [TIME_BITS-1:0]                next_left,
  input  logic signed [dps_pkg::PRI_W-1:0]    next_pri,
  input  logic                                keep_in,
  output logic                                keep_out,
  output logic                                valid,
  output logic [dps_pkg::ID_W-1:0]            id,
  output logic [TIME_BITS-1:0]                used,
  output logic [TIME_BITS-1:0]                left,
  output logic signed [dps_pkg::PRI_W-1:0]    pri
);

  // entry stays in place when it ranks ahead of the new one
  assign keep_out = valid && (ctrl.strict ? (pri > new_pri) : (pri >= new_pri));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (ctrl.op)
        dps_pkg::OP_INSERT: begin
          if (!keep_out) begin
            if (keep_in) begin
              valid <= 1'b1;
            end else begin
              valid <= prev_valid;
            end
          end
        end
        dps_pkg::OP_POP: begin
          valid <= next_valid;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      dps_pkg::OP_INSERT: begin
        if (!keep_out) begin
          if (keep_in) begin
            id   <= new_id;
            used <= new_used;
            left <= new_left;
            pri  <= new_pri;
          end else begin
            id   <= prev_id;
            used <= prev_used;
            left <= prev_left;
            pri  <= prev_pri;
          end
        end
      end
      dps_pkg::OP_POP: begin
        id   <= next_id;
        used <= next_used;
        left <= next_left;
        pri  <= next_pri;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/dynamic_priority_scheduler_unit.sv */
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler_unit
// Priority-ordered process table built as a chain of sorting cells.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): command 0 loads a process (proc_id,
// need_time, start_priority) into the sorted table; command 1 runs one tick
// on the head entry. Output channel (out_valid/out_stall): one result per
// input transaction with status, process fields and the tick count.
// Timing: a transaction is registered on acceptance and executed in the
// EXEC state, where the result is written to the output register. A load
// inserts into the cell chain as it executes. A tick that leaves the
// process unfinished pops the chain, then reinserts the entry in the
// next cycle (REINS state); finished and idle ticks need no reinsert.
// The rate is set by the single compare-and-shift step of the cell chain.
// While the output register holds an untaken result, execution waits;
// the next input is accepted once the unit is back in idle, after any reinsert.
// Reset (rst, synchronous) empties the table and clears the tick count.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_unit #(
  parameter int MAX_PROCS = dps_pkg::DPS_MAX_PROCS,
  parameter int TIME_BITS = dps_pkg::DPS_TIME_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   command,
  input  logic [dps_pkg::ID_W-1:0]               proc_id,
  input  logic [dps_pkg::NEED_W-1:0]             need_time,
  input  logic signed [dps_pkg::PRI_W-1:0]       start_priority,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [2:0]                             status,
  output logic [dps_pkg::ID_W-1:0]               ran_id,
  output logic [dps_pkg::OUT_TIME_W-1:0]         used_time,
  output logic [dps_pkg::OUT_TIME_W-1:0]         left_time,
  output logic signed [dps_pkg::PRI_W-1:0]       new_priority,
  output logic [dps_pkg::CLK_W-1:0]              clock_now
);

  localparam int NW = (TIME_BITS > dps_pkg::NEED_W) ? TIME_BITS : dps_pkg::NEED_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  dps_pkg::state_t   st, st_next;
  dps_pkg::cell_ctrl_t ctrl;

  logic                              cmd_q;
  logic [dps_pkg::ID_W-1:0]          id_q;
  logic [TIME_BITS-1:0]              need_q;
  logic signed [dps_pkg::PRI_W-1:0]  pri_q;

  logic [dps_pkg::ID_W-1:0]          hold_id;
  logic [TIME_BITS-1:0]              hold_used;
  logic [TIME_BITS-1:0]              hold_left;
  logic signed [dps_pkg::PRI_W-1:0]  hold_pri;

  logic [dps_pkg::CLK_W-1:0]         tick_count;

  logic [NW-1:0]                     need_ext;
  logic [TIME_BITS-1:0]              need_sat;

  logic                              c_valid [MAX_PROCS+2];
  logic [dps_pkg::ID_W-1:0]          c_id    [MAX_PROCS+2];
  logic [TIME_BITS-1:0]              c_used  [MAX_PROCS+2];
  logic [TIME_BITS-1:0]              c_left  [MAX_PROCS+2];
  logic signed [dps_pkg::PRI_W-1:0]  c_pri   [MAX_PROCS+2];
  logic                              keep    [MAX_PROCS+1];

  logic [dps_pkg::ID_W-1:0]          ins_id;
  logic [TIME_BITS-1:0]              ins_used;
  logic [TIME_BITS-1:0]              ins_left;
  logic signed [dps_pkg::PRI_W-1:0]  ins_pri;

  logic [TIME_BITS-1:0]              run_used;
  logic [TIME_BITS-1:0]              run_left;
  logic signed [dps_pkg::PRI_W-1:0]  run_pri;
  logic                              run_done;

  logic                              ofree;
  logic                              out_load;
  logic                              hold_load;
  logic                              tick_inc;
  logic                              empty;
  logic                              full;
  logic                              reject;

  dps_pkg::status_t                  res_status;
  logic [dps_pkg::ID_W-1:0]          res_id;
  logic [TIME_BITS-1:0]              res_used;
  logic [TIME_BITS-1:0]              res_left;
  logic signed [dps_pkg::PRI_W-1:0]  res_pri;

  assign need_ext = NW'(need_time);
  assign need_sat = (need_ext > NW'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(need_ext);

  assign in_stall = (st != dps_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      cmd_q  <= command;
      id_q   <= proc_id;
      need_q <= need_sat;
      pri_q  <= start_priority;
    end
  end

  // chain boundaries
  assign c_valid[0]           = 1'b0;
  assign c_id[0]              = '0;
  assign c_used[0]            = '0;
  assign c_left[0]            = '0;
  assign c_pri[0]             = '0;
  assign c_valid[MAX_PROCS+1] = 1'b0;
  assign c_id[MAX_PROCS+1]    = '0;
  assign c_used[MAX_PROCS+1]  = '0;
  assign c_left[MAX_PROCS+1]  = '0;
  assign c_pri[MAX_PROCS+1]   = '0;
  assign keep[0]              = 1'b1;

  for (genvar k = 0; k < MAX_PROCS; k++) begin : g_cell
    dps_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_id     (ins_id),
      .new_used   (ins_used),
      .new_left   (ins_left),
      .new_pri    (ins_pri),
      .prev_valid (c_valid[k]),
      .prev_id    (c_id[k]),
      .prev_used  (c_used[k]),
      .prev_left  (c_left[k]),
      .prev_pri   (c_pri[k]),
      .next_valid (c_valid[k+2]),
      .next_id    (c_id[k+2]),
      .next_used  (c_used[k+2]),
      .next_left  (c_left[k+2]),
      .next_pri   (c_pri[k+2]),
      .keep_in    (keep[k]),
      .keep_out   (keep[k+1]),
      .valid      (c_valid[k+1]),
      .id         (c_id[k+1]),
      .used       (c_used[k+1]),
      .left       (c_left[k+1]),
      .pri        (c_pri[k+1])
    );
  end

  assign empty  = !c_valid[1];
  assign full   = c_valid[MAX_PROCS];
  assign reject = (need_q == '0) || full;

  // head entry after one tick
  assign run_used = (c_used[1] == TIME_MAX) ? TIME_MAX : c_used[1] + 1'b1;
  assign run_left = (c_left[1] == '0) ? '0 : c_left[1] - 1'b1;
  assign run_pri  = (c_pri[1] == dps_pkg::PRI_MIN) ? dps_pkg::PRI_MIN :
                    c_pri[1] - dps_pkg::PRI_W'(1);
  assign run_done = (run_left == '0);

  always_comb begin
    if (st == dps_pkg::ST_REINS) begin
      ins_id   = hold_id;
      ins_used = hold_used;
      ins_left = hold_left;
      ins_pri  = hold_pri;
    end else begin
      ins_id   = id_q;
      ins_used = '0;
      ins_left = need_q;
      ins_pri  = pri_q;
    end
  end

  assign ofree = !out_valid || !out_stall;

  always_comb begin
    st_next     = st;
    ctrl.op     = dps_pkg::OP_HOLD;
    ctrl.strict = 1'b0;
    out_load    = 1'b0;
    hold_load   = 1'b0;
    tick_inc    = 1'b0;
    res_status  = dps_pkg::STAT_IDLE;
    res_id      = '0;
    res_used    = '0;
    res_left    = '0;
    res_pri     = '0;
    case (st)
      dps_pkg::ST_IDLE: begin
        if (in_valid) begin
          st_next = dps_pkg::ST_EXEC;
        end
      end
      dps_pkg::ST_EXEC: begin
        if (cmd_q == dps_pkg::CMD_LOAD) begin
          res_status = reject ? dps_pkg::STAT_REJECTED : dps_pkg::STAT_LOADED;
          res_id     = id_q;
          res_left   = need_q;
          res_pri    = pri_q;
        end else if (!empty) begin
          res_status = run_done ? dps_pkg::STAT_FINISHED : dps_pkg::STAT_RAN;
          res_id     = c_id[1];
          res_used   = run_used;
          res_left   = run_left;
          res_pri    = run_pri;
        end
        if (ofree) begin
          out_load = 1'b1;
          st_next  = dps_pkg::ST_IDLE;
          if (cmd_q == dps_pkg::CMD_LOAD) begin
            if (!reject) begin
              ctrl.op = dps_pkg::OP_INSERT;
            end
          end else if (!empty) begin
            tick_inc  = 1'b1;
            hold_load = 1'b1;
            ctrl.op   = dps_pkg::OP_POP;
            if (!run_done) begin
              st_next = dps_pkg::ST_REINS;
            end
          end
        end
      end
      dps_pkg::ST_REINS: begin
        ctrl.op     = dps_pkg::OP_INSERT;
        ctrl.strict = 1'b1;
        st_next     = dps_pkg::ST_IDLE;
      end
      default: begin
        st_next = dps_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= dps_pkg::ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_load) begin
      hold_id   <= c_id[1];
      hold_used <= run_used;
      hold_left <= run_left;
      hold_pri  <= run_pri;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (tick_inc) begin
      tick_count <= tick_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status       <= res_status;
      ran_id       <= res_id;
      used_time    <= dps_pkg::OUT_TIME_W'(res_used);
      left_time    <= dps_pkg::OUT_TIME_W'(res_left);
      new_priority <= res_pri;
      clock_now    <= tick_inc ? tick_count + 1'b1 : tick_count;
    end
  end

endmodule

/* bench/dps_sched_checker.sv */
// ----------------------------------------------------------------------------
// dps_sched_checker
// Watches both channels of the scheduler, keeps its own copy of the process
// table and tick count, and compares every result transaction against the
// oldest pending prediction. Mismatches and unexpected results are counted.
// ----------------------------------------------------------------------------
module dps_sched_checker
  import dps_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic                      command,
  input  logic [ID_W-1:0]           proc_id,
  input  logic [NEED_W-1:0]         need_time,
  input  logic signed [PRI_W-1:0]   start_priority,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic [2:0]                status,
  input  logic [ID_W-1:0]           ran_id,
  input  logic [OUT_TIME_W-1:0]     used_time,
  input  logic [OUT_TIME_W-1:0]     left_time,
  input  logic signed [PRI_W-1:0]   new_priority,
  input  logic [CLK_W-1:0]          clock_now,
  output int                        mismatches,
  output int                        outstanding
);

  typedef struct packed {
    logic [ID_W-1:0]         id;
    logic [OUT_TIME_W-1:0]   used;
    logic [OUT_TIME_W-1:0]   left;
    logic signed [PRI_W-1:0] pri;
  } proc_entry_t;

  typedef struct packed {
    status_t                 stat;
    logic [ID_W-1:0]         id;
    logic [OUT_TIME_W-1:0]   used;
    logic [OUT_TIME_W-1:0]   left;
    logic signed [PRI_W-1:0] pri;
    logic [CLK_W-1:0]        ticks;
  } sched_result_t;

  proc_entry_t   proc_table [DPS_MAX_PROCS];
  int            proc_count;
  logic [CLK_W-1:0] tick_count;
  sched_result_t pending_results [$];

  function automatic void insert_entry(proc_entry_t e, bit strict);
    int pos;
    pos = 0;
    while (pos < proc_count &&
           (strict ? proc_table[pos].pri > e.pri : proc_table[pos].pri >= e.pri))
      pos++;
    for (int i = proc_count; i > pos; i--)
      proc_table[i] = proc_table[i-1];
    proc_table[pos] = e;
    proc_count++;
  endfunction

  function automatic sched_result_t run_scheduler(logic cmd, logic [ID_W-1:0] id,
                                                  logic [NEED_W-1:0] need,
                                                  logic signed [PRI_W-1:0] pri);
    sched_result_t r;
    proc_entry_t   e;
    int            tmax;
    int            need_sat;
    tmax = (1 << DPS_TIME_BITS) - 1;
    r = '0;
    if (cmd == CMD_LOAD) begin
      need_sat = (int'(need) > tmax) ? tmax : int'(need);
      r.id = id;
      r.left = need_sat[OUT_TIME_W-1:0];
      r.pri = pri;
      if (need_sat == 0 || proc_count >= DPS_MAX_PROCS) begin
        r.stat = STAT_REJECTED;
      end else begin
        e.id = id;
        e.used = '0;
        e.left = need_sat[OUT_TIME_W-1:0];
        e.pri = pri;
        insert_entry(e, 1'b0);
        r.stat = STAT_LOADED;
      end
    end else if (proc_count == 0) begin
      r.stat = STAT_IDLE;
    end else begin
      e = proc_table[0];
      tick_count = tick_count + 1'b1;
      if (int'(e.used) < tmax) e.used = e.used + 1'b1;
      if (e.left != 0) e.left = e.left - 1'b1;
      if (e.pri != PRI_MIN) e.pri = e.pri - PRI_W'(1);
      for (int i = 1; i < proc_count; i++)
        proc_table[i-1] = proc_table[i];
      proc_count--;
      if (e.left == 0) begin
        r.stat = STAT_FINISHED;
      end else begin
        insert_entry(e, 1'b1);
        r.stat = STAT_RAN;
      end
      r.id = e.id;
      r.used = e.used;
      r.left = e.left;
      r.pri = e.pri;
    end
    r.ticks = tick_count;
    return r;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    sched_result_t want;
    if (rst) begin
      proc_count = 0;
      tick_count = '0;
      pending_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with none pending: status %0d, ran_id %0d",
                 status, ran_id);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("status", want.stat, status);
          compare_field("ran_id", want.id, ran_id);
          compare_field("used_time", want.used, used_time);
          compare_field("left_time", want.left, left_time);
          compare_field("new_priority", want.pri, new_priority);
          compare_field("clock_now", want.ticks, clock_now);
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(run_scheduler(command, proc_id, need_time,
                                                start_priority));
    end
    outstanding = pending_results.size();
  end

endmodule

/* bench/dynamic_priority_scheduler_unit_tb.sv */
// ----------------------------------------------------------------------------
// dynamic_priority_scheduler_unit_tb
// Drives load and tick transactions into the scheduler: a directed opening
// (idle tick, rejected loads, full table, priority floor, ties) followed by
// random bursts with a shifting load/tick mix. The receiver stalls on its own
// pattern, including one long hold-off. Checking is done by dps_sched_checker.
// ----------------------------------------------------------------------------
module dynamic_priority_scheduler_unit_tb;
  import dps_pkg::*;

  localparam int RANDOM_ITEMS = 530;
  localparam int CYCLE_LIMIT  = 200000;

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic                    command;
  logic [ID_W-1:0]         proc_id;
  logic [NEED_W-1:0]       need_time;
  logic signed [PRI_W-1:0] start_priority;
  logic                    out_valid;
  logic                    out_stall;
  logic [2:0]              status;
  logic [ID_W-1:0]         ran_id;
  logic [OUT_TIME_W-1:0]   used_time;
  logic [OUT_TIME_W-1:0]   left_time;
  logic signed [PRI_W-1:0] new_priority;
  logic [CLK_W-1:0]        clock_now;

  int          mismatches;
  int          outstanding;
  int          items_sent;
  int unsigned cycle_count;

  dynamic_priority_scheduler_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .proc_id(proc_id), .need_time(need_time),
    .start_priority(start_priority),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .ran_id(ran_id), .used_time(used_time),
    .left_time(left_time), .new_priority(new_priority), .clock_now(clock_now)
  );

  dps_sched_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .proc_id(proc_id), .need_time(need_time),
    .start_priority(start_priority),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .ran_id(ran_id), .used_time(used_time),
    .left_time(left_time), .new_priority(new_priority), .clock_now(clock_now),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_txn(logic cmd, logic [ID_W-1:0] id, logic [NEED_W-1:0] need,
                          logic signed [PRI_W-1:0] pri);
    in_valid       <= 1'b1;
    command        <= cmd;
    proc_id        <= id;
    need_time      <= need;
    start_priority <= pri;
    do @(posedge clk); while (in_stall);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic load_proc(logic [ID_W-1:0] id, logic [NEED_W-1:0] need,
                           logic signed [PRI_W-1:0] pri);
    send_txn(CMD_LOAD, id, need, pri);
  endtask

  task automatic tick();
    send_txn(CMD_TICK, ID_W'($urandom), NEED_W'($urandom), PRI_W'($urandom));
  endtask

  task automatic idle_input(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic drain();
    idle_input(1);
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic send_random(int load_pct);
    logic [NEED_W-1:0]       need;
    logic signed [PRI_W-1:0] pri;
    int                      pick;
    if ($urandom_range(99) < load_pct) begin
      pick = $urandom_range(99);
      if (pick < 10)      need = '0;
      else if (pick < 75) need = NEED_W'($urandom_range(1, 6));
      else if (pick < 93) need = NEED_W'($urandom_range(7, 40));
      else                need = NEED_W'($urandom_range(41, 255));
      if ($urandom_range(1)) pri = PRI_W'(int'($urandom_range(0, 8)) - 4);
      else                   pri = PRI_W'($urandom_range(0, 255));
      load_proc(ID_W'($urandom_range(0, 15)), need, pri);
    end else begin
      tick();
    end
  endtask

  initial begin : receiver
    bit hold_done;
    int mode;
    int run_len;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (!hold_done && items_sent >= 120) begin
        hold_done = 1'b1;
        repeat (80) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
      end
      mode    = $urandom_range(3);
      run_len = $urandom_range(4, 30);
      repeat (run_len) begin
        @(negedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(1));
          2: out_stall <= ~out_stall;
          default: out_stall <= ($urandom_range(3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    int  sent_rand;
    int  burst;
    int  load_pct;
    int  next_shift;
    bit  paused;
    rst            = 1'b1;
    in_valid       = 1'b0;
    command        = CMD_LOAD;
    proc_id        = '0;
    need_time      = '0;
    start_priority = '0;
    items_sent     = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // empty table, floor priority, zero need
    tick();
    load_proc(4'd1, 8'd2, PRI_MIN);
    tick();
    tick();
    load_proc(4'd0, 8'd0, 8'sd5);
    // fill the table, including ties and both priority extremes
    load_proc(4'd2, 8'd255, 8'sd127);
    load_proc(4'd3, 8'd3, 8'sd0);
    load_proc(4'd4, 8'd2, 8'sd0);
    load_proc(4'd5, 8'd1, -8'sd1);
    load_proc(4'd6, 8'd4, 8'sd127);
    load_proc(4'd7, 8'd128, -8'sd127);
    load_proc(4'd8, 8'd2, 8'sd85);
    load_proc(4'd15, 8'd1, PRI_MIN);
    load_proc(4'd10, 8'd5, 8'sd3);
    repeat (9) tick();
    drain();

    sent_rand  = 0;
    next_shift = 0;
    load_pct   = 50;
    paused     = 1'b0;
    while (sent_rand < RANDOM_ITEMS) begin
      if (sent_rand >= next_shift) begin
        case ($urandom_range(2))
          0: load_pct = 25;
          1: load_pct = 50;
          default: load_pct = 75;
        endcase
        next_shift = sent_rand + $urandom_range(30, 80);
      end
      if (!paused && sent_rand >= 300) begin
        paused = 1'b1;
        drain();
      end
      burst = $urandom_range(1, 20);
      repeat (burst) begin
        send_random(load_pct);
        sent_rand++;
      end
      if ($urandom_range(3) != 0) idle_input($urandom_range(1, 6));
    end
    drain();
    repeat (10) @(negedge clk);

    if (mismatches == 0 && outstanding == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
